[hw/rtl/hlg_pkg.sv]
package hlg_pkg;

  localparam int FracBits  = 16;
  localparam int GradSteps = FracBits + 1;
  localparam int TermSteps = 30;
  localparam int MagW      = FracBits + 1;
  localparam int GradFullW = FracBits + 3;
  localparam int StepW     = 6;

  localparam logic [30:0] DeltaReset = 31'd65536;
  localparam logic        RegDelta   = 1'b0;

  localparam logic signed [31:0] GradMax = 32'sd131071;
  localparam logic signed [31:0] GradMin = -32'sd131072;
  localparam logic [63:0]        SumMax  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_GRAD,
    ST_TERM,
    ST_COMMIT
  } hlg_state_e;

  typedef struct packed {
    logic             start;
    logic [31:0]      rem_init;
    logic [63:0]      bits;
    logic [31:0]      divisor;
    logic [StepW-1:0] steps;
  } hlg_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } hlg_div_rsp_t;

endpackage

[hw/rtl/hlg_div.sv]
module hlg_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hlg_pkg::hlg_div_req_t req_i,
  output hlg_pkg::hlg_div_rsp_t rsp_o
);
  import hlg_pkg::*;

  logic [31:0]      rem_q, rem_d;
  logic [63:0]      bits_q, bits_d;
  logic [31:0]      div_q;
  logic [31:0]      quo_q, quo_d;
  logic [StepW-1:0] cnt_q;
  logic             run_q;
  logic             done_q;
  logic [32:0]      trial;
  logic [32:0]      diff;
  logic             ge;

  // one quotient bit per cycle, restoring form
  always_comb begin
    trial  = {rem_q, bits_q[63]};
    diff   = trial - {1'b0, div_q};
    ge     = (trial >= {1'b0, div_q});
    rem_d  = ge ? diff[31:0] : trial[31:0];
    bits_d = {bits_q[62:0], 1'b0};
    quo_d  = {quo_q[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= req_i.steps;
      end else if (run_q) begin
        cnt_q <= cnt_q - StepW'(1);
        if (cnt_q == StepW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem_init;
      bits_q <= req_i.bits;
      div_q  <= req_i.divisor;
      quo_q  <= '0;
    end else if (run_q) begin
      rem_q  <= rem_d;
      bits_q <= bits_d;
      quo_q  <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[hw/rtl/huber_loss_and_gradient_unit.sv]
// channel  | direction | handshake                       | payload
// ---------+-----------+---------------------------------+---------------------------------------
// input    | in        | in_valid_i / in_stall_o         | x_value_i, is_last_i
// output   | out       | out_valid_o / out_stall_i       | gradient_o, loss_sum_o, loss_final_o
// config   | in        | psel_i, penable_i, pwrite_i     | paddr_i, pwdata_i, prdata_o
//
// each beat starts with a 32x32 square, then the shared radix-2 divider
// runs 17 steps for the gradient and 30 steps for the loss term when |x| <= delta;
// beyond the threshold the divider is skipped
// in_stall_o is high from acceptance until the result is handed to the output register
// a finished result waits in the output register while out_stall_i is high
// reset clears the running loss and loads delta with one in fixed point
module huber_loss_and_gradient_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] x_value_i,
  input  logic               is_last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [17:0] gradient_o,
  output logic signed [63:0] loss_sum_o,
  output logic               loss_final_o,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [2:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output logic [31:0]        prdata_o,
  output logic               pready_o
);
  import hlg_pkg::*;

  hlg_state_e   state_q, state_d;
  hlg_div_req_t div_req;
  hlg_div_rsp_t div_rsp;

  logic [30:0]      delta_q;
  logic [31:0]      ax_q;
  logic [30:0]      d_q;
  logic             neg_q;
  logic             last_q;
  logic [63:0]      sq_q;
  logic [MagW-1:0]  mag_q;
  logic [31:0]      term_q;
  logic [63:0]      acc_q, acc_d;

  logic             out_valid_q;
  logic [17:0]      grad_q;
  logic [63:0]      sum_q;
  logic             final_q;

  logic             in_accept;
  logic             out_free;
  logic             in_band;
  logic             commit;
  logic [31:0]      ax_new;
  logic [63:0]      ng;
  logic [64:0]      sum_full;
  logic [63:0]      sum_sat;
  logic signed [GradFullW-1:0] g_full;
  logic signed [31:0] g32;
  logic signed [31:0] g_clamp;

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == RegDelta) ? {1'b0, delta_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= DeltaReset;
    end else if (psel_i && penable_i && pwrite_i && (paddr_i[2] == RegDelta)) begin
      delta_q <= pwdata_i[30:0];
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_band    = (ax_q <= {1'b0, d_q});
  assign ax_new     = x_value_i[31] ? (~x_value_i + 32'd1) : x_value_i;
  assign ng         = 64'(ax_q) << FracBits;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SQUARE;
      ST_SQUARE: state_d = in_band ? ST_GRAD : ST_COMMIT;
      ST_GRAD:   if (div_rsp.done) state_d = ST_TERM;
      ST_TERM:   if (div_rsp.done) state_d = ST_COMMIT;
      ST_COMMIT: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // divider requests and commit strobe
  always_comb begin
    div_req = '0;
    commit  = 1'b0;
    case (state_q)
      ST_SQUARE: begin
        div_req.start    = in_band;
        div_req.rem_init = 32'(ng >> GradSteps);
        div_req.bits     = ng << (64 - GradSteps);
        div_req.divisor  = {1'b0, d_q};
        div_req.steps    = StepW'(GradSteps);
      end
      ST_GRAD: begin
        div_req.start    = div_rsp.done;
        div_req.rem_init = 32'(sq_q >> TermSteps);
        div_req.bits     = sq_q << (64 - TermSteps);
        div_req.divisor  = {d_q, 1'b0};
        div_req.steps    = StepW'(TermSteps);
      end
      ST_COMMIT: commit = out_free;
      default: begin
        div_req = '0;
        commit  = 1'b0;
      end
    endcase
  end

  hlg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ax_q   <= ax_new;
      neg_q  <= x_value_i[31];
      last_q <= is_last_i;
      d_q    <= (delta_q == 31'd0) ? 31'd1 : delta_q;
    end
    if (state_q == ST_SQUARE) begin
      sq_q <= 64'(ax_q) * 64'(ax_q);
      if (!in_band) begin
        mag_q  <= MagW'(1) << FracBits;
        term_q <= ax_q - 32'(d_q >> 1);
      end
    end
    if ((state_q == ST_GRAD) && div_rsp.done) begin
      mag_q <= div_rsp.quotient[MagW-1:0];
    end
    if ((state_q == ST_TERM) && div_rsp.done) begin
      term_q <= div_rsp.quotient;
    end
  end

  // sign, clamp and saturating sum
  always_comb begin
    g_full = $signed({2'b00, mag_q});
    if (neg_q) begin
      g_full = -g_full;
    end
    g32 = {{(32 - GradFullW){g_full[GradFullW-1]}}, g_full};
    if (g32 > GradMax) begin
      g_clamp = GradMax;
    end else if (g32 < GradMin) begin
      g_clamp = GradMin;
    end else begin
      g_clamp = g32;
    end
    sum_full = {1'b0, acc_q} + 65'(term_q);
    sum_sat  = (sum_full > {1'b0, SumMax}) ? SumMax : sum_full[63:0];
    acc_d    = last_q ? 64'd0 : sum_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        acc_q       <= acc_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      grad_q  <= g_clamp[17:0];
      sum_q   <= sum_sat;
      final_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign gradient_o   = $signed(grad_q);
  assign loss_sum_o   = $signed(sum_q);
  assign loss_final_o = final_q;

endmodule
